[hdl/assert_macros.svh]
// assertion macros for the rtl files
// no dependencies; the checks drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CTC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CTC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hdl/ctcgd_pkg.sv]
// types and fixed widths for the ctc greedy decoder
// no dependencies
`default_nettype none
package ctcgd_pkg;
    localparam int PROB_W       = 16;
    localparam int LABEL_W      = 8;
    localparam int FRAME_W      = 8;
    localparam int SCORE_W      = 16;
    localparam int BLANK_W      = 8;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 32;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = 2;
    localparam int FIFO_CW      = 3;

    typedef logic [PROB_W-1:0]      t_prob;
    typedef logic [BLANK_W-1:0]     t_blank;
    typedef logic [IN_TDATA_W-1:0]  t_in_tdata;
    typedef logic [OUT_TDATA_W-1:0] t_out_tdata;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [FRAME_W-1:0] frame_index;
        logic [LABEL_W-1:0] label;
        logic               has_label;
        logic               end_of_sequence;
    } t_result;
endpackage
`default_nettype wire

[hdl/ctc_greedy_decoder.sv]
// ctc greedy decoder: one probability per cycle, running argmax per frame, label collapse
// a result passes through the input register and then the result fifo before it is on m_axis
// throughput: one item per cycle; an item waits in the input register until the result fifo
// has two free slots, so a stalled output or a run of two-result items
// slows the input; reset (i_rst_n, synchronous): blank index 0, state cleared, fifo empty
// depends on ctcgd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module ctc_greedy_decoder #(
    parameter int MAX_CLASSES = 256,
    parameter int MAX_FRAMES  = 256
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire  ctcgd_pkg::t_in_tdata s_axis_tdata,   // [15:0] prob
    input  wire                       s_axis_tlast,   // last_in_frame
    input  wire                       s_axis_tuser,   // last_in_sequence
    output logic                      m_axis_tvalid,
    input  wire                       m_axis_tready,
    output ctcgd_pkg::t_out_tdata     m_axis_tdata,   // [7:0] label, [15:8] frame_index,
                                                      // [31:16] score
    output logic                      m_axis_tlast,   // end_of_sequence
    output logic                      m_axis_tuser,   // has_label
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire  ctcgd_pkg::t_blank   i_cfg_data      // blank_index
);
    import ctcgd_pkg::*;

    localparam int CLS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CC_W  = $clog2(MAX_CLASSES + 1);
    localparam int FRM_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int PW    = (CLS_W > BLANK_W) ? CLS_W : BLANK_W;
    localparam int FX_W  = (FRM_W > FRAME_W) ? FRM_W : FRAME_W;

    // input register
    logic        r_in_vld;
    t_prob       r_in_prob;
    logic        r_in_eof;
    logic        r_in_eos;

    // sequence state
    t_blank             r_blank;
    logic [CC_W-1:0]    r_cls_cnt;
    t_prob              r_best_val;
    logic [CLS_W-1:0]   r_best_cls;
    logic [PW-1:0]      r_pending;
    logic [SCORE_W-1:0] r_run_score;
    logic [FRM_W-1:0]   r_run_frame;
    logic [FRM_W-1:0]   r_frm_cnt;

    // result fifo
    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;

    logic               w_proc;
    logic               w_pop;
    logic               w_cls_ok;
    logic               w_take;
    t_prob              w_fbv;
    logic [CLS_W-1:0]   w_fbc;
    logic [PW-1:0]      w_fbc_ext;
    logic [PW-1:0]      w_blank_ext;
    logic               w_same;
    logic               w_emit;
    logic               w_seq_end;
    logic [PW-1:0]      n_pending;
    logic [SCORE_W-1:0] n_run_score;
    logic [FRM_W-1:0]   n_run_frame;
    logic [FX_W-1:0]    w_cur_frame_ext;
    logic [FX_W-1:0]    w_new_frame_ext;
    t_result            w_res_change;
    t_result            w_res_end;
    t_result            w_slot0;
    logic [1:0]         w_push_n;
    t_result            w_head;

    assign w_proc        = r_in_vld && (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign s_axis_tready = !r_in_vld || w_proc;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (w_proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_prob <= s_axis_tdata[PROB_W-1:0];
            r_in_eof  <= s_axis_tlast;
            r_in_eos  <= s_axis_tuser;
        end
    end

    // running argmax, earliest class wins ties
    always_comb begin
        w_cls_ok    = r_cls_cnt < CC_W'(MAX_CLASSES);
        w_take      = w_cls_ok && ((r_cls_cnt == '0) || (r_in_prob > r_best_val));
        w_fbv       = w_take ? r_in_prob : r_best_val;
        w_fbc       = w_take ? r_cls_cnt[CLS_W-1:0] : r_best_cls;
        w_fbc_ext   = PW'(w_fbc);
        w_blank_ext = PW'(r_blank);
        w_same      = (w_fbc_ext == r_pending);
        w_emit      = r_in_eof && !w_same && (r_pending != w_blank_ext);
        w_seq_end   = r_in_eof && r_in_eos;

        n_pending   = r_pending;
        n_run_score = r_run_score;
        n_run_frame = r_run_frame;
        if (!w_same) begin
            n_pending   = w_fbc_ext;
            n_run_score = w_fbv;
            n_run_frame = r_frm_cnt;
        end else if ((w_fbc_ext != w_blank_ext) && (w_fbv > r_run_score)) begin
            n_run_score = w_fbv;
            n_run_frame = r_frm_cnt;
        end

        w_cur_frame_ext = FX_W'(r_run_frame);
        w_new_frame_ext = FX_W'(n_run_frame);

        w_res_change.label           = r_pending[LABEL_W-1:0];
        w_res_change.frame_index     = w_cur_frame_ext[FRAME_W-1:0];
        w_res_change.score           = r_run_score;
        w_res_change.has_label       = 1'b1;
        w_res_change.end_of_sequence = 1'b0;

        // flush at sequence end, empty terminator when the pending label is blank
        if (n_pending != w_blank_ext) begin
            w_res_end.label       = n_pending[LABEL_W-1:0];
            w_res_end.frame_index = w_new_frame_ext[FRAME_W-1:0];
            w_res_end.score       = n_run_score;
            w_res_end.has_label   = 1'b1;
        end else begin
            w_res_end.label       = '0;
            w_res_end.frame_index = '0;
            w_res_end.score       = '0;
            w_res_end.has_label   = 1'b0;
        end
        w_res_end.end_of_sequence = 1'b1;

        w_slot0  = w_emit ? w_res_change : w_res_end;
        w_push_n = w_proc ? (2'(w_emit) + 2'(w_seq_end)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank     <= '0;
            r_cls_cnt   <= '0;
            r_best_val  <= '0;
            r_best_cls  <= '0;
            r_pending   <= '0;
            r_run_score <= '0;
            r_run_frame <= '0;
            r_frm_cnt   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_blank <= i_cfg_data;
            end
            if (w_proc) begin
                if (!r_in_eof) begin
                    r_best_val <= w_fbv;
                    r_best_cls <= w_fbc;
                    if (w_cls_ok) begin
                        r_cls_cnt <= r_cls_cnt + 1'b1;
                    end
                end else if (w_seq_end) begin
                    r_cls_cnt   <= '0;
                    r_best_val  <= '0;
                    r_best_cls  <= '0;
                    r_pending   <= w_blank_ext;
                    r_run_score <= '0;
                    r_run_frame <= '0;
                    r_frm_cnt   <= '0;
                end else begin
                    r_cls_cnt   <= '0;
                    r_best_val  <= '0;
                    r_best_cls  <= '0;
                    r_pending   <= n_pending;
                    r_run_score <= n_run_score;
                    r_run_frame <= n_run_frame;
                    if (r_frm_cnt < FRM_W'(MAX_FRAMES - 1)) begin
                        r_frm_cnt <= r_frm_cnt + 1'b1;
                    end
                end
            end else if (i_cfg_valid && o_cfg_ready && (r_frm_cnt == '0)) begin
                // blank change before the first frame end also moves the pending label
                r_pending <= PW'(i_cfg_data);
            end
        end
    end

    // result fifo, up to two writes per cycle
    assign w_pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= w_slot0;
        end
        if (w_push_n == 2'd2) begin
            r_fifo[r_wr_ptr + 1'b1] <= w_res_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(w_push_n);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FIFO_CW'(w_push_n) - FIFO_CW'(w_pop);
        end
    end

    assign w_head        = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {w_head.score, w_head.frame_index, w_head.label};
    assign m_axis_tlast  = w_head.end_of_sequence;
    assign m_axis_tuser  = w_head.has_label;

    `CTC_ASSERT(a_fifo_bound, i_clk, i_rst_n, r_count <= FIFO_CW'(FIFO_DEPTH), "result fifo overflow")
    `CTC_ASSERT(a_seq_clear, i_clk, i_rst_n, (w_proc && w_seq_end) |=> (r_frm_cnt == '0 && r_cls_cnt == '0 && m_axis_tvalid), "sequence end did not clear state or give a result")
    `CTC_ASSERT(a_empty_term, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0), "empty result must be a zero terminator")
    `CTC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "results present right after reset")
endmodule
`default_nettype wire
